// ----- sv/gtu_pkg.sv -----
// Shared types and constants for the GBK to UTF-8 stream converter.
`default_nettype none

package gtu_pkg;

   localparam int TABLE_DEPTH_DEF = 8192;
   localparam int ROW_WIDTH = 94;
   localparam int TBL_SUM_W = 14;

   localparam logic [15:0] MAX_OUT_RESET = 16'd256;
   localparam logic [15:0] ROOM_MARGIN = 16'd3;

   localparam logic KIND_TABLE = 1'b0;
   localparam logic KIND_STRING = 1'b1;

   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] LEAD_LO = 8'hA1;
   localparam logic [7:0] LEAD_HI = 8'hF7;
   localparam logic [7:0] TRAIL_LO = 8'hA1;
   localparam logic [7:0] TRAIL_HI = 8'hFE;
   localparam logic [7:0] LEAD_MIN = 8'h81;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] SUBST_CHAR = 8'h3F;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT = 8'h80;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [15:0] CP_NONE = 16'h0000;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  in_byte;
      logic [15:0] word;
   } gtu_item_type;

   typedef struct packed {
      logic        load;
      logic [1:0]  num;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic        term;
      logic [15:0] length;
   } gtu_bundle_type;

endpackage

`default_nettype wire

// ----- sv/gbk_to_utf8_stream_core.sv -----
// Top level of the GBK to UTF-8 stream converter.
// A string byte is registered in the input stage, and its result bytes in the result register, before they are sent.
// Throughput: one item per cycle while each gives at most one result and the output is not stalled;
// an item giving more result bytes holds the three-byte result register while its bytes are sent.
// Reset is synchronous and clears control state and sets max_out to 256; the code
// table is not cleared and its entries are undefined until written.
`default_nettype none

module gbk_to_utf8_stream_core import gtu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_max_out,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_kind,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic [12:0]  req_table_index,
   input  wire logic [15:0]  req_table_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [15:0]       rsp_out_length
);

   gtu_item_type   item;
   gtu_bundle_type bundle;
   logic           retire;
   logic           can_load;

   gtu_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_in_byte(req_in_byte),
      .req_table_index(req_table_index),
      .req_table_word(req_table_word),
      .retire(retire),
      .item(item)
   );

   gtu_conv u_conv (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_out(csr_max_out),
      .item(item),
      .can_load(can_load),
      .retire(retire),
      .bundle(bundle)
   );

   gtu_out_queue u_out_queue (
      .clock(clock),
      .reset(reset),
      .bundle(bundle),
      .can_load(can_load),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .rsp_out_length(rsp_out_length)
   );

endmodule

`default_nettype wire

// ----- sv/gtu_front.sv -----
// Input register stage with the code table memory and its lookup address.
`default_nettype none

module gtu_front import gtu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_kind,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic [12:0]  req_table_index,
   input  wire logic [15:0]  req_table_word,
   input  wire logic         retire,
   output gtu_item_type      item
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [15:0] mem [TABLE_DEPTH];

   logic                 valid_ff, valid_in;
   logic                 kind_ff;
   logic [7:0]           byte_ff;
   logic [15:0]          word_ff;
   logic [7:0]           prev_ff;
   logic                 accept;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [7:0]           lead_off;
   logic [7:0]           trail_off;
   logic [TBL_SUM_W-1:0] idx_sum;

   assign req_stall = valid_ff && !retire;
   assign accept = req_valid && !req_stall;

   assign wr_en = accept && (req_kind == KIND_TABLE) && (32'(req_table_index) < TABLE_DEPTH);
   assign wr_addr = IDX_W'(req_table_index);

   // The table address pairs the previous string byte with the current one.
   assign lead_off = prev_ff - LEAD_LO;
   assign trail_off = req_in_byte - TRAIL_LO;
   assign idx_sum = TBL_SUM_W'(lead_off[6:0]) * TBL_SUM_W'(ROW_WIDTH)
                    + TBL_SUM_W'(trail_off[6:0]);
   assign rd_addr = IDX_W'(idx_sum);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (retire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         byte_ff <= req_in_byte;
      end
      if (accept && (req_kind == KIND_STRING)) begin
         prev_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_table_word;
      end
      if (accept) begin
         word_ff <= mem[rd_addr];
      end
   end

   assign item.valid = valid_ff;
   assign item.kind = kind_ff;
   assign item.in_byte = byte_ff;
   assign item.word = word_ff;

endmodule

`default_nettype wire

// ----- sv/gtu_conv.sv -----
// Conversion decision, string state and the buffer size register.
`default_nettype none

module gtu_conv import gtu_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_max_out,
   input  wire gtu_item_type item,
   input  wire logic         can_load,
   output logic              retire,
   output gtu_bundle_type    bundle
);

   logic [15:0] max_out_ff;
   logic        pend_ff, pend_in;
   logic [7:0]  lead_ff, lead_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        room;
   logic        in_range;
   logic [15:0] cp;
   logic [1:0]  num;
   logic [7:0]  b0, b1, b2;
   logic        term;
   logic [15:0] length;

   assign csr_ready = 1'b1;

   assign room = (max_out_ff >= ROOM_MARGIN) && (cnt_ff < (max_out_ff - ROOM_MARGIN));
   assign in_range = (lead_ff >= LEAD_LO) && (lead_ff <= LEAD_HI)
                     && (item.in_byte >= TRAIL_LO) && (item.in_byte <= TRAIL_HI);
   assign cp = in_range ? item.word : CP_NONE;

   always_comb begin
      num = 2'd0;
      b0 = BYTE_NUL;
      b1 = BYTE_NUL;
      b2 = BYTE_NUL;
      term = 1'b0;
      length = 16'd0;
      pend_in = pend_ff;
      lead_in = lead_ff;
      if (item.kind == KIND_STRING) begin
         if (item.in_byte == BYTE_NUL) begin
            term = 1'b1;
            pend_in = 1'b0;
            lead_in = BYTE_NUL;
            if (pend_ff) begin
               num = 2'd2;
               b0 = SUBST_CHAR;
               length = cnt_ff + 16'd1;
            end else begin
               num = 2'd1;
               length = cnt_ff;
            end
         end else if (pend_ff) begin
            pend_in = 1'b0;
            if (cp == CP_NONE) begin
               num = 2'd1;
               b0 = SUBST_CHAR;
            end else if (cp < TWO_BYTE_LIMIT) begin
               num = 2'd2;
               b0 = UTF8_LEAD2 | {3'b000, cp[10:6]};
               b1 = UTF8_CONT | {2'b00, cp[5:0]};
            end else begin
               num = 2'd3;
               b0 = UTF8_LEAD3 | {4'b0000, cp[15:12]};
               b1 = UTF8_CONT | {2'b00, cp[11:6]};
               b2 = UTF8_CONT | {2'b00, cp[5:0]};
            end
         end else if (room) begin
            if (item.in_byte < ASCII_LIMIT) begin
               num = 2'd1;
               b0 = item.in_byte;
            end else if (item.in_byte >= LEAD_MIN) begin
               pend_in = 1'b1;
               lead_in = item.in_byte;
            end else begin
               num = 2'd1;
               b0 = SUBST_CHAR;
            end
         end
      end
      cnt_in = term ? 16'd0 : (cnt_ff + {14'd0, num});
   end

   assign retire = item.valid && ((num == 2'd0) || can_load);

   assign bundle.load = retire && (num != 2'd0);
   assign bundle.num = num;
   assign bundle.b0 = b0;
   assign bundle.b1 = b1;
   assign bundle.b2 = b2;
   assign bundle.term = term;
   assign bundle.length = length;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= MAX_OUT_RESET;
         pend_ff <= 1'b0;
         lead_ff <= BYTE_NUL;
         cnt_ff <= 16'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_out_ff <= csr_max_out;
         end
         if (retire) begin
            pend_ff <= pend_in;
            lead_ff <= lead_in;
            cnt_ff <= cnt_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      retire && (item.kind == KIND_STRING) && (item.in_byte == BYTE_NUL)
      |=> (cnt_ff == 16'd0) && !pend_ff)
      else $error("string state not cleared after terminator");

   a_pair_closes: assert property (@(posedge clock) disable iff (reset)
      retire && (item.kind == KIND_STRING) && (item.in_byte != BYTE_NUL) && pend_ff
      |=> !pend_ff)
      else $error("lead byte still pending after its trail byte");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      retire && !term
      |=> cnt_ff == ($past(cnt_ff) + {14'd0, $past(num)}))
      else $error("emitted count does not match bytes produced");
`endif

endmodule

`default_nettype wire

// ----- sv/gtu_out_queue.sv -----
// Result register that sends the up to three bytes of one item in order.
`default_nettype none

module gtu_out_queue import gtu_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire gtu_bundle_type bundle,
   output logic                can_load,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last,
   output logic [15:0]         rsp_out_length
);

   logic [1:0]  count_ff, count_in;
   logic [7:0]  s0_ff, s0_in;
   logic [7:0]  s1_ff, s1_in;
   logic [7:0]  s2_ff, s2_in;
   logic        term_ff, term_in;
   logic [15:0] len_ff, len_in;
   logic        pop;

   assign pop = (count_ff != 2'd0) && !rsp_stall;
   assign can_load = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   always_comb begin
      count_in = count_ff;
      s0_in = s0_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      term_in = term_ff;
      len_in = len_ff;
      if (bundle.load) begin
         count_in = bundle.num;
         s0_in = bundle.b0;
         s1_in = bundle.b1;
         s2_in = bundle.b2;
         term_in = bundle.term;
         len_in = bundle.length;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         s0_in = s1_ff;
         s1_in = s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      term_ff <= term_in;
      len_ff <= len_in;
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_out_byte = s0_ff;
   assign rsp_last = term_ff && (count_ff == 2'd1);
   assign rsp_out_length = rsp_last ? len_ff : 16'd0;

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      bundle.load |-> (count_ff == 2'd0) || ((count_ff == 2'd1) && pop))
      else $error("new bytes loaded over bytes not yet sent");

   a_keep_going: assert property (@(posedge clock) disable iff (reset)
      pop && (count_ff > 2'd1) && !bundle.load |=> rsp_valid)
      else $error("remaining bytes of an item were lost");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_byte == BYTE_NUL)
      else $error("terminator result carries a nonzero byte");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the GBK to UTF-8 stream converter core.
module testbench;
   import gtu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic        kind;
      logic [7:0]  in_byte;
      logic [12:0] table_index;
      logic [15:0] table_word;
   } gbk_item_type;

   typedef struct {
      logic [7:0]  out_byte;
      logic        last;
      logic [15:0] out_length;
   } utf8_byte_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [15:0] csr_max_out = MAX_OUT_RESET;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic        req_kind = KIND_STRING;
   logic [7:0]  req_in_byte = BYTE_NUL;
   logic [12:0] req_table_index = '0;
   logic [15:0] req_table_word = '0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire [7:0]   rsp_out_byte;
   wire         rsp_last;
   wire [15:0]  rsp_out_length;

   gbk_item_type   pending_items[$];
   bit             table_loaded[TABLE_DEPTH_DEF];
   logic [7:0]     prev_string_byte = BYTE_NUL;
   int             total_queued = 0;
   int             total_accepted = 0;

   logic [15:0]    code_points[TABLE_DEPTH_DEF];
   logic           lead_held = 1'b0;
   logic [7:0]     lead_byte = BYTE_NUL;
   logic [15:0]    emit_count = '0;
   logic [15:0]    max_out_copy = MAX_OUT_RESET;
   utf8_byte_type  expected_utf8[$];
   int             mismatch_count = 0;

   int             burst_left = 1;
   int             gap_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;
   int             idle_cycles = 0;

   gbk_to_utf8_stream_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_out    (csr_max_out),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_in_byte    (req_in_byte),
      .req_table_index(req_table_index),
      .req_table_word (req_table_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_out_length (rsp_out_length)
   );

   always #5 clock = ~clock;

   function automatic int gbk_table_index(input logic [7:0] hi, input logic [7:0] lo);
      if (hi < LEAD_LO || hi > LEAD_HI || lo < TRAIL_LO || lo > TRAIL_HI) return -1;
      return (int'(hi) - int'(LEAD_LO)) * ROW_WIDTH + (int'(lo) - int'(TRAIL_LO));
   endfunction

   function automatic void push_expected(input logic [7:0] b, input logic last,
                                         input logic [15:0] len);
      utf8_byte_type e;
      e.out_byte = b;
      e.last = last;
      e.out_length = len;
      expected_utf8.push_back(e);
      if (!last) emit_count = emit_count + 16'd1;
   endfunction

   function automatic void predict_utf8(input gbk_item_type it);
      logic [15:0] cp;
      int idx;
      if (it.kind == KIND_TABLE) begin
         if (int'(it.table_index) < TABLE_DEPTH_DEF) code_points[it.table_index] = it.table_word;
      end else if (it.in_byte == BYTE_NUL) begin
         if (lead_held) push_expected(SUBST_CHAR, 1'b0, 16'd0);
         push_expected(BYTE_NUL, 1'b1, emit_count);
         lead_held = 1'b0;
         lead_byte = BYTE_NUL;
         emit_count = '0;
      end else if (lead_held) begin
         lead_held = 1'b0;
         cp = CP_NONE;
         idx = gbk_table_index(lead_byte, it.in_byte);
         if (idx >= 0 && idx < TABLE_DEPTH_DEF) cp = code_points[idx];
         if (cp == CP_NONE) begin
            push_expected(SUBST_CHAR, 1'b0, 16'd0);
         end else if (cp < TWO_BYTE_LIMIT) begin
            push_expected(UTF8_LEAD2 | 8'(cp >> 6), 1'b0, 16'd0);
            push_expected(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0, 16'd0);
         end else begin
            push_expected(UTF8_LEAD3 | 8'(cp >> 12), 1'b0, 16'd0);
            push_expected(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0, 16'd0);
            push_expected(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0, 16'd0);
         end
      end else if (max_out_copy >= ROOM_MARGIN && emit_count < max_out_copy - ROOM_MARGIN) begin
         if (it.in_byte < ASCII_LIMIT) begin
            push_expected(it.in_byte, 1'b0, 16'd0);
         end else if (it.in_byte >= LEAD_MIN) begin
            lead_held = 1'b1;
            lead_byte = it.in_byte;
         end else begin
            push_expected(SUBST_CHAR, 1'b0, 16'd0);
         end
      end
   endfunction

   function automatic logic [15:0] random_code_point();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(1, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2, 3: return 16'($urandom_range(16'h0800, 16'hFFFF));
         4: return CP_NONE;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic void queue_table_write(input int idx, input logic [15:0] word);
      gbk_item_type it;
      it.kind = KIND_TABLE;
      it.in_byte = 8'($urandom);
      it.table_index = 13'(idx);
      it.table_word = word;
      pending_items.push_back(it);
      table_loaded[idx] = 1'b1;
      total_queued++;
   endfunction

   // Any in-range pair of neighboring string bytes gets its table entry loaded first.
   function automatic void queue_string_byte(input logic [7:0] b);
      gbk_item_type it;
      int idx;
      idx = gbk_table_index(prev_string_byte, b);
      if (idx >= 0 && idx < TABLE_DEPTH_DEF && !table_loaded[idx])
         queue_table_write(idx, random_code_point());
      it.kind = KIND_STRING;
      it.in_byte = b;
      it.table_index = 13'($urandom);
      it.table_word = 16'($urandom);
      pending_items.push_back(it);
      prev_string_byte = b;
      total_queued++;
   endfunction

   function automatic void queue_random_string();
      int chars;
      chars = $urandom_range(0, 10);
      for (int i = 0; i < chars; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: queue_string_byte(8'($urandom_range(1, 8'h7F)));
            7, 8, 9, 10, 11, 12, 13: begin
               queue_string_byte(8'($urandom_range(LEAD_LO, LEAD_HI)));
               queue_string_byte(8'($urandom_range(TRAIL_LO, TRAIL_HI)));
            end
            14: begin
               queue_string_byte(8'($urandom_range(LEAD_MIN, 8'hFF)));
               queue_string_byte(8'($urandom_range(1, 8'hFF)));
            end
            15: queue_string_byte(ASCII_LIMIT);
            16, 17: queue_string_byte(8'($urandom_range(1, 8'hFF)));
            18: queue_table_write($urandom_range(0, TABLE_DEPTH_DEF - 1), random_code_point());
            default: queue_string_byte(8'($urandom_range(LEAD_MIN, 8'hFF)));
         endcase
      end
      if ($urandom_range(0, 5) == 0) queue_string_byte(8'($urandom_range(LEAD_MIN, 8'hFF)));
      queue_string_byte(BYTE_NUL);
   endfunction

   task automatic wait_drained();
      while (total_accepted != total_queued || expected_utf8.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      gbk_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_kind <= next_item.kind;
            req_in_byte <= next_item.in_byte;
            req_table_index <= next_item.table_index;
            req_table_word <= next_item.table_word;
            req_valid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_mode_left = $urandom_range(16, 96);
      end else begin
         stall_mode_left = stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_mode_left % 8) < 5);
      endcase
   end

   always @(posedge clock) begin
      gbk_item_type seen;
      utf8_byte_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.kind = req_kind;
            seen.in_byte = req_in_byte;
            seen.table_index = req_table_index;
            seen.table_word = req_table_word;
            predict_utf8(seen);
            total_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_utf8.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: byte %02h last %0d length %0d",
                           rsp_out_byte, rsp_last, rsp_out_length);
            end else begin
               want = expected_utf8.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_last !== want.last ||
                   rsp_out_length !== want.out_length) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("result error: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                              want.out_byte, want.last, want.out_length,
                              rsp_out_byte, rsp_last, rsp_out_length);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] phase_limits[8];
      int phase_target;
      int phase_base;
      phase_limits = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'hFFFF, 16'd0, MAX_OUT_RESET};
      phase_limits[6] = 16'($urandom_range(5, 40));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_table_write(gbk_table_index(8'hA1, 8'hA1), 16'h0041);
      queue_table_write(gbk_table_index(8'hF7, 8'hFE), 16'hFFFF);
      queue_table_write(gbk_table_index(8'hB0, 8'hA1), 16'h07FF);
      queue_table_write(gbk_table_index(8'hB0, 8'hA2), TWO_BYTE_LIMIT);
      queue_table_write(gbk_table_index(8'hB0, 8'hA3), CP_NONE);
      queue_table_write(TABLE_DEPTH_DEF - 1, 16'h8001);
      queue_string_byte(8'h7F);
      queue_string_byte(ASCII_LIMIT);
      queue_string_byte(8'hA1);
      queue_string_byte(8'hA1);
      queue_string_byte(8'hF7);
      queue_string_byte(8'hFE);
      queue_string_byte(8'hB0);
      queue_string_byte(8'hA1);
      queue_string_byte(8'hB0);
      queue_string_byte(8'hA2);
      queue_string_byte(8'hB0);
      queue_string_byte(8'hA3);
      queue_string_byte(8'h81);
      queue_string_byte(8'h40);
      queue_string_byte(8'hFF);
      queue_string_byte(8'hFF);
      queue_string_byte(8'hA1);
      queue_string_byte(8'h01);
      queue_string_byte(8'hB0);
      queue_string_byte(BYTE_NUL);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         csr_max_out <= phase_limits[p];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         max_out_copy = phase_limits[p];
         phase_target = (phase_limits[p] < 16'd5) ? 12 : 40;
         phase_base = total_queued;
         while (total_queued - phase_base < phase_target / 2) queue_random_string();
         wait_drained();
         while (total_queued - phase_base < phase_target) queue_random_string();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/gtu_pkg.sv
sv/gtu_front.sv
sv/gtu_conv.sv
sv/gtu_out_queue.sv
sv/gbk_to_utf8_stream_core.sv
sim/testbench.sv
